[rtl/mh2s_pkg.sv]
// ----------------------------------------------------------------------------
// mh2s_pkg
// Shared constants and types of the streaming MurmurHash2 core: the mixing
// constants, the work queue depth and the entry passed from front to back.
// ----------------------------------------------------------------------------
package mh2s_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam int          QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MIX,
    OP_FOLD
  } mh2s_op_t;

  typedef struct packed {
    mh2s_op_t    op;
    logic [31:0] word;
    logic [31:0] init;
    logic        first;
    logic        last;
  } mh2s_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_K1,
    BK_K2,
    BK_H,
    BK_FOLD,
    BK_F1,
    BK_F2
  } mh2s_state_t;

endpackage

[rtl/mh2s_front.sv]
// ----------------------------------------------------------------------------
// mh2s_front
// Holds the seed register and classifies each request into a full-word mix,
// a tail fold or nothing, with the tail masked and the start value prepared.
// ----------------------------------------------------------------------------
module mh2s_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic [31:0]          in_data_word,
  input  logic [2:0]           in_valid_bytes,
  input  logic                 in_first_item,
  input  logic                 in_last_item,
  input  logic [31:0]          in_total_length,
  output mh2s_pkg::mh2s_entry_t entry
);

  logic [31:0] seed_r;
  logic [31:0] mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  always_comb begin
    mask     = 32'hffffffff;
    entry.op = mh2s_pkg::OP_FOLD;
    case (in_valid_bytes)
      3'd0: begin
        entry.op = mh2s_pkg::OP_NONE;
      end
      3'd1: begin
        mask = 32'h000000ff;
      end
      3'd2: begin
        mask = 32'h0000ffff;
      end
      3'd3: begin
        mask = 32'h00ffffff;
      end
      default: begin
        entry.op = mh2s_pkg::OP_MIX;
      end
    endcase
    entry.word  = in_data_word & mask;
    entry.init  = seed_r ^ in_total_length;
    entry.first = in_first_item;
    entry.last  = in_last_item;
  end

endmodule

[rtl/mh2s_queue.sv]
// ----------------------------------------------------------------------------
// mh2s_queue
// Small register queue that decouples the classifying front from the hash
// sequencer at the back.
// ----------------------------------------------------------------------------
module mh2s_queue #(
  parameter int DEPTH = mh2s_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  mh2s_pkg::mh2s_entry_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output mh2s_pkg::mh2s_entry_t rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mh2s_pkg::mh2s_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/mh2s_back.sv]
// ----------------------------------------------------------------------------
// mh2s_back
// Hash sequencer around one shared 32-bit multiplier: word mixing, tail
// folding and the final avalanche, with a one-entry result register.
// ----------------------------------------------------------------------------
module mh2s_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  mh2s_pkg::mh2s_entry_t q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           out_hash_value
);

  mh2s_pkg::mh2s_state_t state_r, state_nxt;
  logic [31:0] h_r;
  logic [31:0] k_r;
  logic [31:0] word_r;
  logic        last_r;
  logic        out_valid_r;
  logic [31:0] out_hash_r;
  logic        out_free;
  logic        out_load;
  logic [31:0] h_start;
  logic [31:0] mul_a;
  logic [31:0] prod;

  assign out_free       = !out_valid_r || pop;
  assign empty          = !out_valid_r;
  assign out_hash_value = out_hash_r;
  assign h_start        = q_data.first ? q_data.init : h_r;
  assign prod           = mul_a * mh2s_pkg::MIX_MUL;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mh2s_pkg::BK_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            mh2s_pkg::OP_MIX:  state_nxt = mh2s_pkg::BK_K1;
            mh2s_pkg::OP_FOLD: state_nxt = mh2s_pkg::BK_FOLD;
            default:           state_nxt = q_data.last ? mh2s_pkg::BK_F1
                                                       : mh2s_pkg::BK_IDLE;
          endcase
        end
      end
      mh2s_pkg::BK_K1:   state_nxt = mh2s_pkg::BK_K2;
      mh2s_pkg::BK_K2:   state_nxt = mh2s_pkg::BK_H;
      mh2s_pkg::BK_H:    state_nxt = last_r ? mh2s_pkg::BK_F1 : mh2s_pkg::BK_IDLE;
      mh2s_pkg::BK_FOLD: state_nxt = last_r ? mh2s_pkg::BK_F1 : mh2s_pkg::BK_IDLE;
      mh2s_pkg::BK_F1:   state_nxt = mh2s_pkg::BK_F2;
      mh2s_pkg::BK_F2:   state_nxt = out_free ? mh2s_pkg::BK_IDLE : mh2s_pkg::BK_F2;
      default:           state_nxt = mh2s_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    case (state_r)
      mh2s_pkg::BK_IDLE: q_pop    = !q_empty;
      mh2s_pkg::BK_K1:   mul_a    = word_r;
      mh2s_pkg::BK_K2:   mul_a    = k_r ^ (k_r >> mh2s_pkg::MIX_SHIFT);
      mh2s_pkg::BK_H:    mul_a    = h_r;
      mh2s_pkg::BK_FOLD: mul_a    = h_r ^ word_r;
      mh2s_pkg::BK_F1:   mul_a    = h_r ^ (h_r >> mh2s_pkg::FIN_SHIFT_A);
      mh2s_pkg::BK_F2:   out_load = out_free;
      default:           mul_a    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh2s_pkg::BK_IDLE;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        h_r <= h_start;
      end else if (state_r == mh2s_pkg::BK_H) begin
        h_r <= prod ^ k_r;
      end else if (state_r == mh2s_pkg::BK_FOLD) begin
        h_r <= prod;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r <= q_data.word;
      last_r <= q_data.last;
    end
    if (state_r == mh2s_pkg::BK_K1 || state_r == mh2s_pkg::BK_K2 ||
        state_r == mh2s_pkg::BK_F1) begin
      k_r <= prod;
    end
    if (out_load) begin
      out_hash_r <= k_r ^ (k_r >> mh2s_pkg::FIN_SHIFT_B);
    end
  end

endmodule

[rtl/murmurhash2_stream_core.sv]
// A last full word passes the states K1, K2, H, F1 and F2 before its hash shows.
// The shared multiplier sequencer visits IDLE alone for an empty item, IDLE and
// FOLD for a tail and IDLE, K1, K2 and H for a full word; a last item adds F1
// and F2, where F2 waits for a free result register. The queue in front of the
// sequencer accepts requests while it works, until full. Reset is synchronous
// and active low; it clears the seed, running hash, queue and result valid flag.
// ----------------------------------------------------------------------------
// murmurhash2_stream_core
// Streaming 32-bit MurmurHash2 over little-endian key words.
// ----------------------------------------------------------------------------
module murmurhash2_stream_core #(
  parameter int QUEUE_DEPTH = mh2s_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [31:0] in_total_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_hash_value
);

  mh2s_pkg::mh2s_entry_t front_entry;
  mh2s_pkg::mh2s_entry_t q_data;
  logic                  q_empty;
  logic                  q_pop;

  mh2s_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .in_total_length (in_total_length),
    .entry           (front_entry)
  );

  mh2s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  mh2s_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value)
  );

endmodule

[rtl/mh2s_checker.sv]
// ----------------------------------------------------------------------------
// mh2s_checker
// Port-level checks of the streaming MurmurHash2 core, bound to the top level.
// ----------------------------------------------------------------------------
module mh2s_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_hash_value
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue flags not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_hash_value))
    else $error("waiting result changed before it was taken");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without a request");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(rst_n, 1) && $past(rst_n, 2))
    else $error("result appeared too soon after reset");

endmodule

bind murmurhash2_stream_core mh2s_checker u_mh2s_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_hash_value (out_hash_value)
);
